[src/hbvc_pkg.sv]
// Shared types, constants and tables for the heading band velocity command block.
`timescale 1ns / 1ps

package hbvc_pkg;

    // Angle accumulator counts 2^-16 degree
    localparam int ACC_W       = 26;
    localparam int GUARD_BITS  = 24;
    localparam int TABLE_LEN   = 24;
    localparam int DEG90       = 90 * 65536;

    // atan(2^-i) in 2^-16 degree
    localparam int ATAN_TAB [TABLE_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // Heading error in sixteenths of a degree
    localparam int HEAD_W      = 14;
    localparam int HEAD_SHIFT  = 12;
    localparam int ROUND_HALF  = 2048;
    localparam int HEAD_MIN    = -1440;
    localparam int HEAD_MAX    = 4320;
    localparam int MAG_W       = 13;

    // Config register fields
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int LIMIT_W     = 8;
    localparam int SPEED_W     = 10;
    localparam int NUM_BANDS   = 4;

    // Angular speed: round(32*|h| / d) via reciprocal multiply, d = 5 or 25
    localparam int NUM_W       = MAG_W + 5;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_5     = 3355444;
    localparam int RECIP_25    = 671089;
    localparam int HALF_5      = 2;
    localparam int HALF_25     = 12;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;
    localparam int ANG_W       = 14;
    localparam int ANG_MAX     = 8191;
    localparam int ANG_NEG_MAG = 8192;

    typedef logic signed [ACC_W-1:0] t_angle;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_LIMIT,
        CFG_SECOND_LIMIT,
        CFG_THIRD_LIMIT,
        CFG_FOURTH_LIMIT,
        CFG_CENTER_SPEED,
        CFG_SECOND_SPEED,
        CFG_THIRD_SPEED,
        CFG_FOURTH_SPEED
    } t_cfg_reg;

    typedef enum logic [2:0] {
        BAND_CENTER,
        BAND_SECOND,
        BAND_THIRD,
        BAND_FOURTH,
        BAND_OUTER
    } t_band;

    // Status of the angle pipeline output
    typedef struct packed {
        logic valid;
        logic zero;
    } t_cordic_ctl;

endpackage

[src/hbvc_cordic.sv]
// Pipelined vectoring CORDIC: atan2(num, den) in 2^-16 degree, one stage per step.
`timescale 1ns / 1ps

module hbvc_cordic #(
    parameter int VECTOR_WIDTH     = 21,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [VECTOR_WIDTH-1:0] i_num,
    input  logic signed [VECTOR_WIDTH-1:0] i_den,
    output hbvc_pkg::t_cordic_ctl          o_ctl,
    output hbvc_pkg::t_angle               o_angle
);
    import hbvc_pkg::*;

    localparam int DW = VECTOR_WIDTH + GUARD_BITS + 3;
    localparam int N  = ANGLE_ITERATIONS;

    logic signed [DW-1:0] w_num;
    logic signed [DW-1:0] w_den;
    logic signed [DW-1:0] n_a0;
    logic signed [DW-1:0] n_b0;
    t_angle               n_acc0;

    logic signed [DW-1:0] r_a   [0:N];
    logic signed [DW-1:0] r_b   [0:N];
    t_angle               r_acc [0:N];
    logic                 r_zero[0:N];
    logic                 r_vld [0:N];

    // Scale inputs by the guard bits
    assign w_num = {{3{i_num[VECTOR_WIDTH-1]}}, i_num, {GUARD_BITS{1'b0}}};
    assign w_den = {{3{i_den[VECTOR_WIDTH-1]}}, i_den, {GUARD_BITS{1'b0}}};

    // Left half plane: turn by 90 degrees toward the right half plane
    always_comb begin
        if (w_den[DW-1]) begin
            if (!w_num[DW-1]) begin
                n_a0   = w_num;
                n_b0   = -w_den;
                n_acc0 = ACC_W'(DEG90);
            end else begin
                n_a0   = -w_num;
                n_b0   = w_den;
                n_acc0 = -ACC_W'(DEG90);
            end
        end else begin
            n_a0   = w_den;
            n_b0   = w_num;
            n_acc0 = '0;
        end
    end

    // Entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_a[0]    <= n_a0;
        r_b[0]    <= n_b0;
        r_acc[0]  <= n_acc0;
        r_zero[0] <= (i_num == '0) && (i_den == '0);
    end

    // One micro-rotation per stage
    for (genvar k = 0; k < N; k++) begin : g_step
        logic signed [DW-1:0] w_da;
        logic signed [DW-1:0] w_db;

        assign w_da = r_b[k] >>> k;
        assign w_db = r_a[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            if (!r_b[k][DW-1]) begin
                r_a[k+1]   <= r_a[k] + w_da;
                r_b[k+1]   <= r_b[k] - w_db;
                r_acc[k+1] <= r_acc[k] + ACC_W'(ATAN_TAB[k]);
            end else begin
                r_a[k+1]   <= r_a[k] - w_da;
                r_b[k+1]   <= r_b[k] + w_db;
                r_acc[k+1] <= r_acc[k] - ACC_W'(ATAN_TAB[k]);
            end
            r_zero[k+1] <= r_zero[k];
        end
    end

    // Zero vector gives angle zero
    assign o_ctl.valid = r_vld[N];
    assign o_ctl.zero  = r_zero[N];
    assign o_angle     = r_zero[N] ? '0 : r_acc[N];

endmodule

[src/heading_band_velocity_command.sv]
// Heading band velocity command: heading error, band and speed commands from a vector sum.
// A start transfer passes the CORDIC entry and step registers and stages H, B, M and O to o_valid.
// Throughput: one item per cycle; the CORDIC steps and the divide-by-constant multiply are pipelined.
// Reset (synchronous, active low) clears all valid bits and loads the band register defaults.
// Results are strobed for one cycle; the receiver cannot stall, so busy is high only in reset.
`timescale 1ns / 1ps

module heading_band_velocity_command #(
    parameter int VECTOR_WIDTH     = 21,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic signed [VECTOR_WIDTH-1:0]       i_x_sum,
    input  logic signed [VECTOR_WIDTH-1:0]       i_y_sum,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hbvc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hbvc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_valid,
    output logic signed [hbvc_pkg::HEAD_W-1:0]   o_heading_error,
    output logic [2:0]                           o_band_index,
    output logic [hbvc_pkg::SPEED_W-1:0]         o_linear_speed,
    output logic signed [hbvc_pkg::ANG_W-1:0]    o_angular_speed
);
    import hbvc_pkg::*;

    localparam int HRAW_W  = ACC_W + 1 - HEAD_SHIFT;
    localparam int LATENCY = ANGLE_ITERATIONS + 5;

    logic        w_accept;
    t_cordic_ctl c_ctl;
    t_angle      c_angle;

    // Band registers
    logic [LIMIT_W-1:0] r_limit [NUM_BANDS];
    logic [SPEED_W-1:0] r_speed [NUM_BANDS];

    assign o_busy      = !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_accept    = i_start && !o_busy;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit[0] <= LIMIT_W'(2);
            r_limit[1] <= LIMIT_W'(10);
            r_limit[2] <= LIMIT_W'(25);
            r_limit[3] <= LIMIT_W'(40);
            r_speed[0] <= SPEED_W'(200);
            r_speed[1] <= SPEED_W'(150);
            r_speed[2] <= SPEED_W'(100);
            r_speed[3] <= SPEED_W'(60);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_CENTER_LIMIT: r_limit[0] <= i_cfg_data[LIMIT_W-1:0];
                CFG_SECOND_LIMIT: r_limit[1] <= i_cfg_data[LIMIT_W-1:0];
                CFG_THIRD_LIMIT:  r_limit[2] <= i_cfg_data[LIMIT_W-1:0];
                CFG_FOURTH_LIMIT: r_limit[3] <= i_cfg_data[LIMIT_W-1:0];
                CFG_CENTER_SPEED: r_speed[0] <= i_cfg_data[SPEED_W-1:0];
                CFG_SECOND_SPEED: r_speed[1] <= i_cfg_data[SPEED_W-1:0];
                CFG_THIRD_SPEED:  r_speed[2] <= i_cfg_data[SPEED_W-1:0];
                CFG_FOURTH_SPEED: r_speed[3] <= i_cfg_data[SPEED_W-1:0];
            endcase
        end
    end

    // Angle pipeline: atan2(x, y)
    hbvc_cordic #(
        .VECTOR_WIDTH     (VECTOR_WIDTH),
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_num   (i_x_sum),
        .i_den   (i_y_sum),
        .o_ctl   (c_ctl),
        .o_angle (c_angle)
    );

    // ---- Stage H: add 90 degrees, round to 1/16 degree, clamp ----
    logic signed [ACC_W:0]    n_deg;
    logic signed [HRAW_W-1:0] n_hraw;
    logic signed [HEAD_W-1:0] n_head;
    logic                     r_h_vld;
    logic signed [HEAD_W-1:0] r_h_head;

    always_comb begin
        n_deg  = $signed({c_angle[ACC_W-1], c_angle}) + (ACC_W+1)'(DEG90)
               + (ACC_W+1)'(ROUND_HALF);
        n_hraw = n_deg[ACC_W:HEAD_SHIFT];
        if (n_hraw < HRAW_W'(HEAD_MIN)) begin
            n_head = HEAD_W'(HEAD_MIN);
        end else if (n_hraw > HRAW_W'(HEAD_MAX)) begin
            n_head = HEAD_W'(HEAD_MAX);
        end else begin
            n_head = n_hraw[HEAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= c_ctl.valid;
        end
        r_h_head <= n_head;
    end

    // ---- Stage B: band select, speed, divider operand ----
    logic [MAG_W-1:0]         n_mag;
    t_band                    n_band;
    logic [SPEED_W-1:0]       n_lin;
    logic [NUM_W-1:0]         n_num;
    logic                     r_b_vld;
    logic signed [HEAD_W-1:0] r_b_head;
    t_band                    r_b_band;
    logic [SPEED_W-1:0]       r_b_lin;
    logic [NUM_W-1:0]         r_b_num;
    logic [RECIP_W-1:0]       r_b_recip;

    always_comb begin
        n_mag = r_h_head[HEAD_W-1] ? MAG_W'(-r_h_head) : MAG_W'(r_h_head);
        priority if (n_mag <= {1'b0, r_limit[0], 4'b0}) begin
            n_band = BAND_CENTER;
            n_lin  = r_speed[0];
        end else if (n_mag <= {1'b0, r_limit[1], 4'b0}) begin
            n_band = BAND_SECOND;
            n_lin  = r_speed[1];
        end else if (n_mag <= {1'b0, r_limit[2], 4'b0}) begin
            n_band = BAND_THIRD;
            n_lin  = r_speed[2];
        end else if (n_mag <= {1'b0, r_limit[3], 4'b0}) begin
            n_band = BAND_FOURTH;
            n_lin  = r_speed[3];
        end else begin
            n_band = BAND_OUTER;
            n_lin  = '0;
        end
        n_num = {n_mag, 5'b0}
              + NUM_W'((n_band == BAND_CENTER) ? HALF_5 : HALF_25);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_h_vld;
        end
        r_b_head  <= r_h_head;
        r_b_band  <= n_band;
        r_b_lin   <= n_lin;
        r_b_num   <= n_num;
        r_b_recip <= RECIP_W'((n_band == BAND_CENTER) ? RECIP_5 : RECIP_25);
    end

    // ---- Stage M: reciprocal multiply ----
    logic                     r_m_vld;
    logic signed [HEAD_W-1:0] r_m_head;
    t_band                    r_m_band;
    logic [SPEED_W-1:0]       r_m_lin;
    logic [PROD_W-1:0]        r_m_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= r_b_vld;
        end
        r_m_head <= r_b_head;
        r_m_band <= r_b_band;
        r_m_lin  <= r_b_lin;
        r_m_prod <= PROD_W'(r_b_num) * PROD_W'(r_b_recip);
    end

    // ---- Stage O: quotient, sign, saturation, output register ----
    logic [QUO_W-1:0]         n_quo;
    logic signed [ANG_W-1:0]  n_ang;
    logic                     r_o_vld;
    logic signed [HEAD_W-1:0] r_o_head;
    t_band                    r_o_band;
    logic [SPEED_W-1:0]       r_o_lin;
    logic signed [ANG_W-1:0]  r_o_ang;

    always_comb begin
        n_quo = r_m_prod[PROD_W-1:RECIP_SHIFT];
        if (r_m_head[HEAD_W-1]) begin
            if (n_quo > QUO_W'(ANG_NEG_MAG)) begin
                n_ang = -ANG_W'(ANG_NEG_MAG);
            end else begin
                n_ang = ANG_W'(-$signed({1'b0, n_quo}));
            end
        end else begin
            if (n_quo > QUO_W'(ANG_MAX)) begin
                n_ang = ANG_W'(ANG_MAX);
            end else begin
                n_ang = n_quo[ANG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_m_vld;
        end
        r_o_head <= r_m_head;
        r_o_band <= r_m_band;
        r_o_lin  <= r_m_lin;
        r_o_ang  <= n_ang;
    end

    assign o_valid         = r_o_vld;
    assign o_heading_error = r_o_head;
    assign o_band_index    = r_o_band;
    assign o_linear_speed  = r_o_lin;
    assign o_angular_speed = r_o_ang;

    // ---- Checks ----
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result strobe without a matching start transfer");

    a_outer_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_band_index == BAND_OUTER)) |-> (o_linear_speed == '0))
        else $error("nonzero linear speed in outer band");

    a_turn_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_angular_speed < 0) == (o_heading_error < 0))
                 && ((o_angular_speed == 0) == (o_heading_error == 0)))
        else $error("angular speed sign disagrees with heading error");

endmodule
